// ===== rtl/tlvd_pkg.sv =====
// Shared types, codes and sizes for the TLV compressed-IP header demux.
// No dependencies; the top, cell, chain and testbench files refer to this package.
`timescale 1ns / 1ps
`default_nettype none
package tlvd_pkg;

  localparam int CTX_DEPTH = 16;
  localparam int SLOT_W    = (CTX_DEPTH > 1) ? $clog2(CTX_DEPTH) : 1;
  localparam int CNT_W     = $clog2(CTX_DEPTH + 1);
  localparam int CMP_W     = (CNT_W > 5) ? CNT_W : 5;
  localparam int ID_W      = 12;

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_BYTE  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [1:0] REG_MAX_CTX = 2'd0;
  localparam logic [1:0] REG_FILT_EN = 2'd1;
  localparam logic [1:0] REG_SEL_CTX = 2'd2;

  localparam logic [7:0] TYPE_IPV6 = 8'h02;
  localparam logic [7:0] TYPE_CIP  = 8'h03;
  localparam logic [7:0] TYPE_PAD  = 8'hfe;
  localparam logic [7:0] TYPE_NULL = 8'hff;

  localparam logic [7:0] CIP_MODE_A = 8'h20;
  localparam logic [7:0] CIP_MODE_B = 8'h21;
  localparam logic [7:0] CIP_MODE_C = 8'h60;
  localparam logic [7:0] CIP_MODE_D = 8'h61;
  localparam logic [5:0] SKIP_A     = 6'd20;
  localparam logic [5:0] SKIP_B     = 6'd2;
  localparam logic [5:0] SKIP_C     = 6'd42;
  localparam logic [5:0] SKIP_D     = 6'd0;

  localparam logic [15:0] IPV6_MIN_LEN = 16'd48;
  localparam logic [15:0] IPV6_HDR_LEN = 16'd40;
  localparam logic [15:0] CIP_MIN_LEN  = 16'd3;
  localparam logic [15:0] UDP_MIN_LEN  = 16'd8;
  localparam logic [7:0]  NH_UDP       = 8'd17;
  localparam logic [15:0] NTP_PORT     = 16'd123;

  typedef enum logic [3:0] {
    ST_FORWARD   = 4'd0,
    ST_NTP_OK    = 4'd1,
    ST_IGNORED   = 4'd2,
    ST_FILTERED  = 4'd3,
    ST_BAD_TYPE  = 4'd4,
    ST_SHORT_IP6 = 4'd5,
    ST_BAD_NH    = 4'd6,
    ST_IP6_LEN   = 4'd7,
    ST_UDP_LEN   = 4'd8,
    ST_PORT      = 4'd9,
    ST_SHORT_CIP = 4'd10,
    ST_BAD_MODE  = 4'd11,
    ST_SHORT_CTX = 4'd12,
    ST_CTX_LIMIT = 4'd13
  } status_t;

  typedef enum logic [3:0] {
    K_SKIP = 4'b0001,
    K_IPV6 = 4'b0010,
    K_CIP  = 4'b0100,
    K_FWD  = 4'b1000
  } kind_t;

  typedef struct packed {
    logic              hit;
    logic              refuse;
    logic              fresh;
    logic [SLOT_W-1:0] slot;
  } lookup_t;

  typedef struct packed {
    logic        result_kind;
    status_t     status;
    logic [11:0] ctx_id;
    logic [3:0]  context_slot;
    logic        new_context;
    logic [7:0]  payload_byte;
    logic        payload_last;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/tlvd_if.sv =====
// Valid/ready channel interfaces for input items, results and configuration.
// Depends on nothing; used by tlv_ip_header_demux_top.
`timescale 1ns / 1ps
`default_nettype none
interface tlvd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  packet_type;
  logic [15:0] packet_size;
  logic [7:0]  data_byte;
  modport source (output valid, mode, packet_type, packet_size, data_byte, input ready);
  modport sink   (input valid, mode, packet_type, packet_size, data_byte, output ready);
endinterface

interface tlvd_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [3:0]  status;
  logic [11:0] ctx_id;
  logic [3:0]  context_slot;
  logic        new_context;
  logic [7:0]  payload_byte;
  logic        payload_last;
  modport source (output valid, result_kind, status, ctx_id, context_slot,
                  new_context, payload_byte, payload_last, input ready);
  modport sink   (input valid, result_kind, status, ctx_id, context_slot,
                  new_context, payload_byte, payload_last, output ready);
endinterface

interface tlvd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [11:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/tlv_ip_header_demux_top.sv =====
// Top level of the TLV compressed-IP header demux: byte parser and output register.
// Results are registered; the context lookup is a parallel compare in the cell row.
// Throughput: one item per cycle while the output is not stalled.
// Reset: synchronous, active low; the table empties and configuration returns to defaults.
// Depends on tlvd_pkg, tlvd_if and tlvd_chain.
`timescale 1ns / 1ps
`default_nettype none
module tlv_ip_header_demux_top (
  input  wire logic    clk,
  input  wire logic    rst_n,
  tlvd_in_if.sink      in_chan,
  tlvd_out_if.source   out_chan,
  tlvd_cfg_if.sink     cfg_chan
);
  logic [4:0]  max_ctx_r;
  logic        filt_en_r;
  logic [11:0] sel_ctx_r;

  tlvd_pkg::kind_t kind_r, kind_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [15:0] len_r, len_nxt;
  logic        ver_ok_r, ver_ok_nxt;
  logic [15:0] ip_len_r, ip_len_nxt;
  logic [15:0] udp_len_r, udp_len_nxt;
  logic [15:0] port_r, port_nxt;
  logic [5:0]  skip_r, skip_nxt;
  logic [tlvd_pkg::SLOT_W-1:0] slot_r, slot_nxt;
  logic [11:0] id_r, id_nxt;

  logic                res_vld;
  tlvd_pkg::result_t   res;
  logic                out_vld_r;
  tlvd_pkg::result_t   out_r;

  logic in_acc, cfg_acc, tbl_clr, lookup_en;
  tlvd_pkg::lookup_t lk;
  logic [7:0]  b;
  logic [15:0] udp_now;
  logic [5:0]  skip_sel;
  logic        skip_bad;

  assign in_chan.ready  = !out_vld_r || out_chan.ready;
  assign cfg_chan.ready = 1'b1;
  assign in_acc  = in_chan.valid && in_chan.ready;
  assign cfg_acc = cfg_chan.valid && cfg_chan.ready;
  assign b       = in_chan.data_byte;
  assign udp_now = {udp_len_r[7:0], b};

  always_comb begin
    skip_bad = 1'b0;
    case (b)
      tlvd_pkg::CIP_MODE_A: skip_sel = tlvd_pkg::SKIP_A;
      tlvd_pkg::CIP_MODE_B: skip_sel = tlvd_pkg::SKIP_B;
      tlvd_pkg::CIP_MODE_C: skip_sel = tlvd_pkg::SKIP_C;
      tlvd_pkg::CIP_MODE_D: skip_sel = tlvd_pkg::SKIP_D;
      default: begin
        skip_sel = tlvd_pkg::SKIP_D;
        skip_bad = 1'b1;
      end
    endcase
  end

  tlvd_chain u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr      (tbl_clr),
    .lookup_en(lookup_en),
    .key      (id_r),
    .max_ctx  (max_ctx_r),
    .lk       (lk)
  );

  always_comb begin
    kind_nxt    = kind_r;
    pos_nxt     = pos_r;
    len_nxt     = len_r;
    ver_ok_nxt  = ver_ok_r;
    ip_len_nxt  = ip_len_r;
    udp_len_nxt = udp_len_r;
    port_nxt    = port_r;
    skip_nxt    = skip_r;
    slot_nxt    = slot_r;
    id_nxt      = id_r;
    tbl_clr     = 1'b0;
    lookup_en   = 1'b0;
    res_vld     = 1'b0;
    res         = '0;
    if (cfg_acc && cfg_chan.index == tlvd_pkg::REG_SEL_CTX) begin
      tbl_clr  = 1'b1;
      kind_nxt = tlvd_pkg::K_SKIP;
    end else if (in_acc) begin
      if (in_chan.mode == tlvd_pkg::MODE_START) begin
        kind_nxt    = tlvd_pkg::K_SKIP;
        pos_nxt     = '0;
        len_nxt     = in_chan.packet_size;
        ver_ok_nxt  = 1'b0;
        ip_len_nxt  = '0;
        udp_len_nxt = '0;
        port_nxt    = '0;
        skip_nxt    = '0;
        id_nxt      = '0;
        if (in_chan.packet_type == tlvd_pkg::TYPE_IPV6) begin
          if (in_chan.packet_size < tlvd_pkg::IPV6_MIN_LEN) begin
            res_vld    = 1'b1;
            res.status = tlvd_pkg::ST_SHORT_IP6;
          end else begin
            kind_nxt   = tlvd_pkg::K_IPV6;
            ver_ok_nxt = 1'b1;
          end
        end else if (in_chan.packet_type == tlvd_pkg::TYPE_CIP) begin
          if (in_chan.packet_size < tlvd_pkg::CIP_MIN_LEN) begin
            res_vld    = 1'b1;
            res.status = tlvd_pkg::ST_SHORT_CIP;
          end else begin
            kind_nxt = tlvd_pkg::K_CIP;
          end
        end else if (in_chan.packet_type == tlvd_pkg::TYPE_PAD ||
                     in_chan.packet_type == tlvd_pkg::TYPE_NULL) begin
          res_vld    = 1'b1;
          res.status = tlvd_pkg::ST_IGNORED;
        end else begin
          res_vld    = 1'b1;
          res.status = tlvd_pkg::ST_BAD_TYPE;
        end
      end else if (in_chan.mode == tlvd_pkg::MODE_CLEAR) begin
        tbl_clr  = 1'b1;
        kind_nxt = tlvd_pkg::K_SKIP;
      end else if (in_chan.mode == tlvd_pkg::MODE_BYTE &&
                   kind_r != tlvd_pkg::K_SKIP && pos_r < len_r) begin
        pos_nxt = pos_r + 16'd1;
        case (kind_r)
          tlvd_pkg::K_IPV6: begin
            if (pos_r == 16'd0 && b[7:4] != 4'd6) ver_ok_nxt = 1'b0;
            if (pos_r == 16'd6 && b != tlvd_pkg::NH_UDP) ver_ok_nxt = 1'b0;
            if (pos_r == 16'd4 || pos_r == 16'd5) ip_len_nxt = {ip_len_r[7:0], b};
            if (pos_r == 16'd42 || pos_r == 16'd43) port_nxt = {port_r[7:0], b};
            if (pos_r == 16'd44 || pos_r == 16'd45) udp_len_nxt = udp_now;
            if (pos_r == 16'd45) begin
              res_vld  = 1'b1;
              kind_nxt = tlvd_pkg::K_SKIP;
              if (!ver_ok_r) begin
                res.status = tlvd_pkg::ST_BAD_NH;
              end else if (ip_len_r != len_r - tlvd_pkg::IPV6_HDR_LEN) begin
                res.status = tlvd_pkg::ST_IP6_LEN;
              end else if (udp_now < tlvd_pkg::UDP_MIN_LEN ||
                           udp_now != len_r - tlvd_pkg::IPV6_HDR_LEN) begin
                res.status = tlvd_pkg::ST_UDP_LEN;
              end else if (port_r != tlvd_pkg::NTP_PORT) begin
                res.status = tlvd_pkg::ST_PORT;
              end else begin
                res.status = tlvd_pkg::ST_NTP_OK;
              end
            end
          end
          tlvd_pkg::K_CIP: begin
            if (pos_r == 16'd0) begin
              id_nxt = {b, 4'd0};
            end else if (pos_r == 16'd1) begin
              id_nxt = {id_r[11:4], b[7:4]};
            end else if (pos_r == 16'd2) begin
              kind_nxt       = tlvd_pkg::K_SKIP;
              res_vld        = 1'b1;
              res.ctx_id     = id_r;
              if (filt_en_r && sel_ctx_r != id_r) begin
                res.status = tlvd_pkg::ST_FILTERED;
              end else if (skip_bad) begin
                res.status = tlvd_pkg::ST_BAD_MODE;
              end else if (len_r - tlvd_pkg::CIP_MIN_LEN < 16'(skip_sel)) begin
                res.status = tlvd_pkg::ST_SHORT_CTX;
              end else begin
                lookup_en = 1'b1;
                if (lk.refuse) begin
                  res.status = tlvd_pkg::ST_CTX_LIMIT;
                end else begin
                  res.status       = tlvd_pkg::ST_FORWARD;
                  res.context_slot = 4'(lk.slot);
                  res.new_context  = lk.fresh;
                  skip_nxt         = skip_sel;
                  slot_nxt         = lk.slot;
                  kind_nxt         = tlvd_pkg::K_FWD;
                end
              end
            end
          end
          tlvd_pkg::K_FWD: begin
            if (pos_r >= tlvd_pkg::CIP_MIN_LEN + 16'(skip_r)) begin
              res_vld          = 1'b1;
              res.result_kind  = 1'b1;
              res.status       = tlvd_pkg::ST_FORWARD;
              res.ctx_id       = id_r;
              res.context_slot = 4'(slot_r);
              res.payload_byte = b;
              if (pos_r + 16'd1 == len_r) begin
                res.payload_last = 1'b1;
                kind_nxt         = tlvd_pkg::K_SKIP;
              end
            end
          end
          default: begin
            kind_nxt = tlvd_pkg::K_SKIP;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r    <= tlvd_pkg::K_SKIP;
      out_vld_r <= 1'b0;
      max_ctx_r <= 5'd16;
      filt_en_r <= 1'b0;
      sel_ctx_r <= '0;
      pos_r     <= '0;
      len_r     <= '0;
      ver_ok_r  <= 1'b0;
      ip_len_r  <= '0;
      udp_len_r <= '0;
      port_r    <= '0;
      skip_r    <= '0;
      slot_r    <= '0;
      id_r      <= '0;
    end else begin
      kind_r    <= kind_nxt;
      pos_r     <= pos_nxt;
      len_r     <= len_nxt;
      ver_ok_r  <= ver_ok_nxt;
      ip_len_r  <= ip_len_nxt;
      udp_len_r <= udp_len_nxt;
      port_r    <= port_nxt;
      skip_r    <= skip_nxt;
      slot_r    <= slot_nxt;
      id_r      <= id_nxt;
      if (in_chan.ready) begin
        out_vld_r <= res_vld;
      end
      if (cfg_acc) begin
        case (cfg_chan.index)
          tlvd_pkg::REG_MAX_CTX: max_ctx_r <= cfg_chan.data[4:0];
          tlvd_pkg::REG_FILT_EN: filt_en_r <= cfg_chan.data[0];
          tlvd_pkg::REG_SEL_CTX: sel_ctx_r <= cfg_chan.data;
          default: ;
        endcase
      end
    end
    if (in_chan.ready && res_vld) begin
      out_r <= res;
    end
  end

  assign out_chan.valid        = out_vld_r;
  assign out_chan.result_kind  = out_r.result_kind;
  assign out_chan.status       = out_r.status;
  assign out_chan.ctx_id       = out_r.ctx_id;
  assign out_chan.context_slot = out_r.context_slot;
  assign out_chan.new_context  = out_r.new_context;
  assign out_chan.payload_byte = out_r.payload_byte;
  assign out_chan.payload_last = out_r.payload_last;
endmodule
`default_nettype wire

// ===== rtl/tlvd_cell.sv =====
// One context table cell: a stored id with its valid bit and match compare.
// Passes the free-slot-seen flag on to its neighbor. Depends on tlvd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tlvd_cell (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    clr,
  input  wire logic                    ins,
  input  wire logic [tlvd_pkg::ID_W-1:0] key,
  input  wire logic                    free_in,
  output logic                         free_out,
  output logic                         first_free,
  output logic                         match,
  output logic                         vld
);
  logic                      vld_r, vld_nxt;
  logic [tlvd_pkg::ID_W-1:0] id_r, id_nxt;

  assign first_free = !vld_r && !free_in;
  assign free_out   = free_in || !vld_r;
  assign match      = vld_r && (id_r == key);
  assign vld        = vld_r;

  always_comb begin
    vld_nxt = vld_r;
    id_nxt  = id_r;
    if (clr) begin
      vld_nxt = 1'b0;
    end else if (ins && first_free) begin
      vld_nxt = 1'b1;
      id_nxt  = key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    id_r <= id_nxt;
  end
endmodule
`default_nettype wire

// ===== rtl/tlvd_chain.sv =====
// Row of context cells forming the lookup table, plus the fill count.
// Depends on tlvd_pkg and tlvd_cell.
`timescale 1ns / 1ps
`default_nettype none
module tlvd_chain (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    clr,
  input  wire logic                    lookup_en,
  input  wire logic [tlvd_pkg::ID_W-1:0] key,
  input  wire logic [4:0]              max_ctx,
  output tlvd_pkg::lookup_t            lk
);
  localparam int N = tlvd_pkg::CTX_DEPTH;

  logic [N:0]   free_chain;
  logic [N-1:0] first_free;
  logic [N-1:0] match;
  logic [N-1:0] vld;
  logic [tlvd_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [tlvd_pkg::CMP_W-1:0] limit;
  logic [tlvd_pkg::SLOT_W-1:0] hit_slot, free_slot;
  logic ins;

  assign free_chain[0] = 1'b0;

  for (genvar g = 0; g < N; g++) begin : g_cell
    tlvd_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .clr       (clr),
      .ins       (ins),
      .key       (key),
      .free_in   (free_chain[g]),
      .free_out  (free_chain[g+1]),
      .first_free(first_free[g]),
      .match     (match[g]),
      .vld       (vld[g])
    );
  end

  always_comb begin
    hit_slot  = '0;
    free_slot = '0;
    for (int i = 0; i < N; i++) begin
      if (match[i]) hit_slot = hit_slot | tlvd_pkg::SLOT_W'(i);
      if (first_free[i]) free_slot = free_slot | tlvd_pkg::SLOT_W'(i);
    end
  end

  always_comb begin
    if (tlvd_pkg::CMP_W'(max_ctx) > tlvd_pkg::CMP_W'(N)) begin
      limit = tlvd_pkg::CMP_W'(N);
    end else begin
      limit = tlvd_pkg::CMP_W'(max_ctx);
    end
  end

  assign lk.hit    = |match;
  assign lk.refuse = !(|match) &&
                     ((tlvd_pkg::CMP_W'(cnt_r) >= limit) || !free_chain[N]);
  assign lk.fresh  = !(|match);
  assign lk.slot   = (|match) ? hit_slot : free_slot;
  assign ins       = lookup_en && !lk.hit && !lk.refuse && !clr;

  always_comb begin
    cnt_nxt = cnt_r;
    if (clr) begin
      cnt_nxt = '0;
    end else if (ins) begin
      cnt_nxt = cnt_r + tlvd_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_count_tracks_cells: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) == 32'($countones(vld)))
    else $error("fill count differs from number of valid cells");
  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match))
    else $error("context id stored in more than one cell");
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    clr |=> (cnt_r == '0) && (vld == '0))
    else $error("table not empty after clear");
endmodule
`default_nettype wire

// ===== test/tlv_ip_header_demux_top_test.sv =====
// Self-checking testbench for tlv_ip_header_demux_top: random packets, stalls and settings.
// Depends on tlvd_pkg, the channel interfaces of tlvd_if and the block itself.
`timescale 1ns / 1ps
module tlv_ip_header_demux_top_test;
  import tlvd_pkg::*;

  typedef struct {
    logic [1:0]  mode;
    logic [7:0]  ptype;
    logic [15:0] psize;
    logic [7:0]  data;
  } tlv_item_t;

  typedef enum {PK_SKIP, PK_IPV6, PK_CIP, PK_FWD} parse_kind_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tlvd_in_if  in_chan();
  tlvd_out_if out_chan();
  tlvd_cfg_if cfg_chan();

  tlv_ip_header_demux_top uut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan), .cfg_chan(cfg_chan)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  tlv_item_t item_q[$];
  result_t   want_results[$];
  tlv_item_t drv_item;
  int        errors = 0;
  int        gap_left = 0;
  int        gap_style = 0;
  int        sent_count = 0;
  int        hold_left = 0;
  logic      long_stall_req = 1'b0;
  logic      long_stall_done = 1'b0;

  // Shadow of the block's state.
  logic [4:0]  sh_max;
  logic        sh_filt;
  logic [11:0] sh_sel;
  logic [11:0] sh_ids[CTX_DEPTH];
  logic        sh_used[CTX_DEPTH];
  int          sh_count;
  parse_kind_e sh_kind;
  int          sh_pos;
  int          sh_len;
  logic        sh_ver_ok;
  logic [15:0] sh_ip_len;
  logic [15:0] sh_udp_len;
  logic [15:0] sh_port;
  int          sh_skip;
  logic [3:0]  sh_slot;
  logic [11:0] sh_id;

  function automatic void empty_table();
    for (int i = 0; i < CTX_DEPTH; i++) begin
      sh_ids[i] = '0;
      sh_used[i] = 1'b0;
    end
    sh_count = 0;
    sh_kind = PK_SKIP;
  endfunction

  function automatic void push_result(logic kind, status_t st, logic [11:0] id,
                                      logic [3:0] slot, logic fresh, logic [7:0] b,
                                      logic last);
    result_t r;
    r.result_kind = kind;
    r.status = st;
    r.ctx_id = id;
    r.context_slot = slot;
    r.new_context = fresh;
    r.payload_byte = b;
    r.payload_last = last;
    want_results.push_back(r);
  endfunction

  function automatic status_t find_context(logic [11:0] id, output logic [3:0] slot,
                                           output logic fresh);
    int limit;
    limit = (sh_max > CTX_DEPTH) ? CTX_DEPTH : int'(sh_max);
    slot = '0;
    fresh = 1'b0;
    for (int i = 0; i < CTX_DEPTH; i++) begin
      if (sh_used[i] && sh_ids[i] == id) begin
        slot = 4'(i);
        return ST_FORWARD;
      end
    end
    if (sh_count >= limit) return ST_CTX_LIMIT;
    for (int i = 0; i < CTX_DEPTH; i++) begin
      if (!sh_used[i]) begin
        sh_used[i] = 1'b1;
        sh_ids[i] = id;
        sh_count++;
        slot = 4'(i);
        fresh = 1'b1;
        return ST_FORWARD;
      end
    end
    return ST_CTX_LIMIT;
  endfunction

  function automatic void predict_item(tlv_item_t it);
    int         pos;
    int         skip;
    logic [3:0] slot;
    logic       fresh;
    status_t    st;
    if (it.mode == MODE_START) begin
      sh_kind = PK_SKIP;
      sh_pos = 0;
      sh_len = it.psize;
      sh_ver_ok = 1'b0;
      sh_ip_len = '0;
      sh_udp_len = '0;
      sh_port = '0;
      sh_skip = 0;
      sh_id = '0;
      if (it.ptype == TYPE_IPV6) begin
        if (it.psize < IPV6_MIN_LEN) push_result(1'b0, ST_SHORT_IP6, '0, '0, 1'b0, '0, 1'b0);
        else begin
          sh_kind = PK_IPV6;
          sh_ver_ok = 1'b1;
        end
      end else if (it.ptype == TYPE_CIP) begin
        if (it.psize < CIP_MIN_LEN) push_result(1'b0, ST_SHORT_CIP, '0, '0, 1'b0, '0, 1'b0);
        else sh_kind = PK_CIP;
      end else if (it.ptype == TYPE_PAD || it.ptype == TYPE_NULL) begin
        push_result(1'b0, ST_IGNORED, '0, '0, 1'b0, '0, 1'b0);
      end else begin
        push_result(1'b0, ST_BAD_TYPE, '0, '0, 1'b0, '0, 1'b0);
      end
      return;
    end
    if (it.mode == MODE_CLEAR) begin
      empty_table();
      return;
    end
    if (it.mode != MODE_BYTE || sh_kind == PK_SKIP || sh_pos >= sh_len) return;
    pos = sh_pos;
    sh_pos++;
    case (sh_kind)
      PK_IPV6: begin
        if (pos == 0 && it.data[7:4] != 4'd6) sh_ver_ok = 1'b0;
        if (pos == 6 && it.data != NH_UDP) sh_ver_ok = 1'b0;
        if (pos == 4 || pos == 5) sh_ip_len = {sh_ip_len[7:0], it.data};
        if (pos == 42 || pos == 43) sh_port = {sh_port[7:0], it.data};
        if (pos == 44 || pos == 45) sh_udp_len = {sh_udp_len[7:0], it.data};
        if (pos == 45) begin
          if (!sh_ver_ok) st = ST_BAD_NH;
          else if (sh_ip_len != sh_len - 40) st = ST_IP6_LEN;
          else if (sh_udp_len < UDP_MIN_LEN || sh_udp_len != sh_len - 40) st = ST_UDP_LEN;
          else if (sh_port != NTP_PORT) st = ST_PORT;
          else st = ST_NTP_OK;
          sh_kind = PK_SKIP;
          push_result(1'b0, st, '0, '0, 1'b0, '0, 1'b0);
        end
      end
      PK_CIP: begin
        if (pos == 0) sh_id = {it.data, 4'h0};
        else if (pos == 1) sh_id[3:0] = it.data[7:4];
        else if (pos == 2) begin
          sh_kind = PK_SKIP;
          if (sh_filt && sh_sel != sh_id) begin
            push_result(1'b0, ST_FILTERED, sh_id, '0, 1'b0, '0, 1'b0);
            return;
          end
          if (it.data == CIP_MODE_A) skip = SKIP_A;
          else if (it.data == CIP_MODE_B) skip = SKIP_B;
          else if (it.data == CIP_MODE_C) skip = SKIP_C;
          else if (it.data == CIP_MODE_D) skip = SKIP_D;
          else begin
            push_result(1'b0, ST_BAD_MODE, sh_id, '0, 1'b0, '0, 1'b0);
            return;
          end
          if (sh_len - 3 < skip) begin
            push_result(1'b0, ST_SHORT_CTX, sh_id, '0, 1'b0, '0, 1'b0);
            return;
          end
          st = find_context(sh_id, slot, fresh);
          if (st != ST_FORWARD) begin
            push_result(1'b0, st, sh_id, '0, 1'b0, '0, 1'b0);
            return;
          end
          sh_skip = skip;
          sh_slot = slot;
          sh_kind = PK_FWD;
          push_result(1'b0, ST_FORWARD, sh_id, slot, fresh, '0, 1'b0);
        end
      end
      default: begin
        if (pos < 3 + sh_skip) return;
        if (pos + 1 == sh_len) begin
          sh_kind = PK_SKIP;
          push_result(1'b1, ST_FORWARD, sh_id, sh_slot, 1'b0, it.data, 1'b1);
        end else begin
          push_result(1'b1, ST_FORWARD, sh_id, sh_slot, 1'b0, it.data, 1'b0);
        end
      end
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (gap_style == 0) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      in_chan.mode <= '0;
      in_chan.packet_type <= '0;
      in_chan.packet_size <= '0;
      in_chan.data_byte <= '0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        predict_item(drv_item);
        sent_count++;
        if (sent_count % 80 == 0) gap_style = $urandom_range(0, 2);
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_chan.valid <= 1'b0;
        end else if (item_q.size() != 0) begin
          drv_item = item_q.pop_front();
          in_chan.mode <= drv_item.mode;
          in_chan.packet_type <= drv_item.ptype;
          in_chan.packet_size <= drv_item.psize;
          in_chan.data_byte <= drv_item.data;
          in_chan.valid <= 1'b1;
          gap_left = pick_gap();
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    result_t w;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (want_results.size() == 0) begin
          $display("%0t: unexpected result kind=%0d status=%0d id=%0d", $time,
                   out_chan.result_kind, out_chan.status, out_chan.ctx_id);
          errors++;
        end else begin
          w = want_results.pop_front();
          if (out_chan.result_kind !== w.result_kind || out_chan.status !== w.status ||
              out_chan.ctx_id !== w.ctx_id || out_chan.context_slot !== w.context_slot ||
              out_chan.new_context !== w.new_context || out_chan.payload_byte !== w.payload_byte ||
              out_chan.payload_last !== w.payload_last) begin
            $display("%0t: mismatch expected kind=%0d st=%0d id=%0d slot=%0d new=%0d b=%0d last=%0d",
                     $time, w.result_kind, w.status, w.ctx_id, w.context_slot,
                     w.new_context, w.payload_byte, w.payload_last);
            $display("%0t:          actual   kind=%0d st=%0d id=%0d slot=%0d new=%0d b=%0d last=%0d",
                     $time, out_chan.result_kind, out_chan.status, out_chan.ctx_id,
                     out_chan.context_slot, out_chan.new_context, out_chan.payload_byte,
                     out_chan.payload_last);
            errors++;
          end
        end
      end
      if (long_stall_req && !long_stall_done) begin
        long_stall_done <= 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (gap_style == 0) begin
        out_chan.ready <= 1'b1;
      end else begin
        if ($urandom_range(0, 99) < 8) hold_left = $urandom_range(1, 3);
        else if ($urandom_range(0, 99) < 2) hold_left = $urandom_range(10, 40);
        out_chan.ready <= (hold_left == 0);
      end
    end
  end

  task automatic add_item(logic [1:0] mode, logic [7:0] ptype, logic [15:0] psize,
                          logic [7:0] data);
    tlv_item_t it;
    it.mode = mode;
    it.ptype = ptype;
    it.psize = psize;
    it.data = data;
    item_q.push_back(it);
  endtask

  // Sends a start and then "count" bytes; fields of the IPv6/UDP header are placed.
  task automatic add_ipv6(int size, int count, logic [3:0] ver, logic [7:0] nh,
                          logic [15:0] ip_len, logic [15:0] udp_len, logic [15:0] port);
    logic [7:0] b;
    add_item(MODE_START, TYPE_IPV6, 16'(size), 8'($urandom));
    for (int i = 0; i < count; i++) begin
      b = 8'($urandom);
      case (i)
        0: b = {ver, b[3:0]};
        4: b = ip_len[15:8];
        5: b = ip_len[7:0];
        6: b = nh;
        42: b = port[15:8];
        43: b = port[7:0];
        44: b = udp_len[15:8];
        45: b = udp_len[7:0];
        default: ;
      endcase
      add_item(MODE_BYTE, 8'($urandom), 16'($urandom), b);
    end
  endtask

  task automatic add_good_ipv6(int size);
    add_ipv6(size, size, 4'd6, NH_UDP, 16'(size - 40), 16'(size - 40), NTP_PORT);
  endtask

  task automatic add_cip(int size, int count, logic [11:0] id, logic [7:0] hmode);
    logic [7:0] b;
    add_item(MODE_START, TYPE_CIP, 16'(size), 8'($urandom));
    for (int i = 0; i < count; i++) begin
      b = 8'($urandom);
      if (i == 0) b = id[11:4];
      if (i == 1) b = {id[3:0], b[3:0]};
      if (i == 2) b = hmode;
      add_item(MODE_BYTE, 8'($urandom), 16'($urandom), b);
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [11:0] value);
    @(posedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data <= value;
    do @(posedge clk); while (!cfg_chan.ready);
    if (idx == REG_MAX_CTX) sh_max = value[4:0];
    else if (idx == REG_FILT_EN) sh_filt = value[0];
    else if (idx == REG_SEL_CTX) begin
      sh_sel = value;
      empty_table();
    end
    cfg_chan.valid <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk); while (item_q.size() != 0 || in_chan.valid || want_results.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_hmode();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return CIP_MODE_D;
    if (r < 5) return CIP_MODE_B;
    if (r < 7) return CIP_MODE_A;
    if (r < 9) return CIP_MODE_C;
    return 8'($urandom);
  endfunction

  task automatic add_random_traffic(int n_items, logic [11:0] keep_id);
    logic [11:0] pool[20];
    int          r;
    int          size;
    logic [7:0]  hm;
    logic [7:0]  t;
    int          stop_at;
    for (int i = 0; i < 20; i++) pool[i] = 12'($urandom);
    pool[0] = 12'h000;
    pool[1] = 12'hfff;
    pool[2] = keep_id;
    stop_at = item_q.size() + n_items;
    while (item_q.size() < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        hm = pick_hmode();
        size = (hm == CIP_MODE_C && $urandom_range(0, 3) != 0) ? $urandom_range(45, 60)
                                                               : $urandom_range(3, 30);
        add_cip(size, size, pool[$urandom_range(0, $urandom_range(0, 1) ? 5 : 19)], hm);
      end else if (r < 70) begin
        size = $urandom_range(48, 70);
        case ($urandom_range(0, 7))
          0: add_ipv6(size, size, 4'($urandom), NH_UDP, 16'(size - 40), 16'(size - 40),
                      NTP_PORT);
          1: add_ipv6(size, size, 4'd6, 8'($urandom), 16'(size - 40), 16'(size - 40),
                      NTP_PORT);
          2: add_ipv6(size, size, 4'd6, NH_UDP, 16'($urandom), 16'(size - 40), NTP_PORT);
          3: add_ipv6(size, size, 4'd6, NH_UDP, 16'(size - 40), 16'($urandom_range(0, 9)),
                      NTP_PORT);
          4: add_ipv6(size, size, 4'd6, NH_UDP, 16'(size - 40), 16'(size - 40),
                      16'($urandom));
          default: add_good_ipv6(size);
        endcase
      end else if (r < 78) begin
        t = 8'($urandom);
        if ($urandom_range(0, 1)) t = $urandom_range(0, 1) ? TYPE_PAD : TYPE_NULL;
        add_item(MODE_START, t, 16'($urandom), 8'($urandom));
      end else if (r < 82) begin
        add_item($urandom_range(0, 1) ? MODE_CLEAR : 2'd3, 8'($urandom), 16'($urandom),
                 8'($urandom));
      end else if (r < 87) begin
        add_item(MODE_BYTE, 8'($urandom), 16'($urandom), 8'($urandom));
      end else if (r < 94) begin
        size = $urandom_range(0, 1) ? 16'hffff : $urandom_range(3, 60);
        if ($urandom_range(0, 1)) add_cip(size, $urandom_range(0, 8), pool[$urandom_range(0, 5)],
                                          pick_hmode());
        else add_ipv6(size, $urandom_range(0, 50), 4'd6, NH_UDP, 16'(size - 40),
                      16'(size - 40), NTP_PORT);
      end else if (r < 97) begin
        add_item(MODE_START, TYPE_IPV6, 16'($urandom_range(0, 47)), 8'($urandom));
      end else begin
        add_cip(5, 5, pool[$urandom_range(0, 5)], CIP_MODE_D);
        repeat ($urandom_range(1, 4)) add_item(MODE_BYTE, 8'($urandom), 16'($urandom),
                                               8'($urandom));
      end
    end
  endtask

  initial begin
    in_chan.valid = 1'b0;
    in_chan.mode = '0;
    in_chan.packet_type = '0;
    in_chan.packet_size = '0;
    in_chan.data_byte = '0;
    out_chan.ready = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.index = '0;
    cfg_chan.data = '0;
    sh_max = 5'd16;
    sh_filt = 1'b0;
    sh_sel = '0;
    empty_table();
    sh_pos = 0;
    sh_len = 0;
    sh_ver_ok = 1'b0;
    sh_ip_len = '0;
    sh_udp_len = '0;
    sh_port = '0;
    sh_skip = 0;
    sh_slot = '0;
    sh_id = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed packets: every verdict except filtered and context limit, and each header mode.
    add_item(MODE_START, 8'h00, 16'hffff, 8'hff);
    add_item(MODE_START, TYPE_PAD, 16'd5, 8'h00);
    add_item(MODE_START, TYPE_NULL, 16'd0, 8'h00);
    add_item(MODE_BYTE, 8'h00, 16'd0, 8'hff);
    add_item(MODE_START, TYPE_IPV6, 16'd47, 8'h00);
    add_item(MODE_START, TYPE_CIP, 16'd2, 8'h00);
    add_good_ipv6(48);
    add_ipv6(50, 50, 4'd4, NH_UDP, 16'd10, 16'd10, NTP_PORT);
    add_ipv6(50, 50, 4'd6, 8'd6, 16'd10, 16'd10, NTP_PORT);
    add_ipv6(50, 50, 4'd6, NH_UDP, 16'd11, 16'd10, NTP_PORT);
    add_ipv6(47 + 1, 48, 4'd6, NH_UDP, 16'd8, 16'd7, NTP_PORT);
    add_ipv6(50, 50, 4'd6, NH_UDP, 16'd10, 16'd10, 16'd53);
    add_cip(8, 8, 12'h000, CIP_MODE_D);
    add_cip(10, 10, 12'hfff, CIP_MODE_B);
    add_cip(25, 25, 12'h123, CIP_MODE_A);
    add_cip(47, 47, 12'h456, CIP_MODE_C);
    add_cip(6, 6, 12'h789, 8'h55);
    add_cip(20, 20, 12'h789, CIP_MODE_C);
    add_item(2'd3, 8'h00, 16'd0, 8'h00);
    add_item(MODE_CLEAR, 8'h00, 16'd0, 8'h00);
    add_cip(4, 4, 12'hfff, CIP_MODE_D);
    drain();

    write_reg(REG_MAX_CTX, 12'd3);
    write_reg(REG_FILT_EN, 12'd0);
    write_reg(REG_SEL_CTX, 12'd0);
    long_stall_req <= 1'b1;
    add_random_traffic(150, 12'h000);
    drain();
    write_reg(REG_MAX_CTX, 12'd0);
    add_random_traffic(80, 12'h000);
    drain();
    write_reg(REG_MAX_CTX, 12'd16);
    write_reg(REG_SEL_CTX, 12'hfff);
    write_reg(REG_FILT_EN, 12'd1);
    add_random_traffic(130, 12'hfff);
    drain();
    write_reg(REG_SEL_CTX, 12'h5a3);
    add_random_traffic(100, 12'h5a3);
    drain();
    write_reg(REG_FILT_EN, 12'd0);
    write_reg(REG_MAX_CTX, 12'd31);
    add_random_traffic(200, 12'h000);
    drain();
    write_reg(REG_MAX_CTX, 12'd1);
    add_random_traffic(100, 12'h000);
    drain();
    write_reg(REG_MAX_CTX, 12'd16);
    add_random_traffic(110, 12'h000);
    drain();

    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #4ms;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/tlvd_pkg.sv
rtl/tlvd_if.sv
rtl/tlvd_cell.sv
rtl/tlvd_chain.sv
rtl/tlv_ip_header_demux_top.sv
test/tlv_ip_header_demux_top_test.sv
